>>> design/assert_macros.svh
// Assertion macros used by the file that checks the touch frame validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while the synchronous active-low reset is held.
`define TFV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("touch frame validator check failed");

// Clocked check that also holds during reset.
`define TFV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("touch frame validator check failed");

`endif

>>> design/tfv_pkg.sv
// Types and constants shared by the touch frame validator modules.
`default_nettype none

package tfv_pkg;

    // Frame layout and limits.
    localparam int unsigned FRAME_BYTES = 8;
    localparam logic [3:0]  MAX_POINTS  = 4'd5;
    localparam logic [7:0]  BYTE_ALL_ONES = 8'hFF;

    // Stream widths.
    localparam int unsigned IN_TDATA_W  = 8 * FRAME_BYTES;
    localparam int unsigned OUT_TDATA_W = 56;
    localparam int unsigned OUT_TUSER_W = 2;

    // Configuration port.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_SWAP_AXES     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIRROR_H      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIRROR_V      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_HEIGHT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAW_X_LIMIT   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAW_Y_LIMIT   = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_INVALID_LIMIT = 3'd7;

    // Configuration reset values.
    localparam logic [12:0] RST_SCREEN_SIZE   = 13'd4096;
    localparam logic [12:0] RST_RAW_LIMIT     = 13'd4096;
    localparam logic [15:0] RST_INVALID_LIMIT = 16'd50;

    // Result status codes.
    localparam logic [1:0] ST_REPORT  = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_BUS     = 2'd3;

    // Touch event codes.
    localparam logic [1:0] EV_DOWN     = 2'd0;
    localparam logic [1:0] EV_RELEASE  = 2'd1;
    localparam logic [1:0] EV_CONTACT  = 2'd2;
    localparam logic [1:0] EV_RESERVED = 2'd3;

    typedef struct packed {
        logic        swap_axes;
        logic        mirror_horizontal;
        logic        mirror_vertical;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [12:0] raw_x_limit;
        logic [12:0] raw_y_limit;
        logic [15:0] invalid_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic        point_count;
        logic [15:0] x_coord;
        logic [15:0] y_coord;
        logic [1:0]  touch_event;
        logic [3:0]  touch_id;
        logic [7:0]  pressure_weight;
        logic [3:0]  contact_area;
        logic        recover_request;
    } t_result;

endpackage

`default_nettype wire

>>> design/tfv_cfg_regs.sv
// Configuration register file of the touch frame validator.
`default_nettype none

module tfv_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tfv_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [tfv_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output tfv_pkg::t_cfg                         o_cfg
);

    tfv_pkg::t_cfg r_cfg;
    tfv_pkg::t_cfg n_cfg;

    // Decode the write index and update one field.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                tfv_pkg::CFG_SWAP_AXES:     n_cfg.swap_axes         = i_cfg_wdata[0];
                tfv_pkg::CFG_MIRROR_H:      n_cfg.mirror_horizontal = i_cfg_wdata[0];
                tfv_pkg::CFG_MIRROR_V:      n_cfg.mirror_vertical   = i_cfg_wdata[0];
                tfv_pkg::CFG_SCREEN_WIDTH:  n_cfg.screen_width      = i_cfg_wdata[12:0];
                tfv_pkg::CFG_SCREEN_HEIGHT: n_cfg.screen_height     = i_cfg_wdata[12:0];
                tfv_pkg::CFG_RAW_X_LIMIT:   n_cfg.raw_x_limit       = i_cfg_wdata[12:0];
                tfv_pkg::CFG_RAW_Y_LIMIT:   n_cfg.raw_y_limit       = i_cfg_wdata[12:0];
                tfv_pkg::CFG_INVALID_LIMIT: n_cfg.invalid_limit     = i_cfg_wdata;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    // Registers with their reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swap_axes         <= 1'b0;
            r_cfg.mirror_horizontal <= 1'b0;
            r_cfg.mirror_vertical   <= 1'b0;
            r_cfg.screen_width      <= tfv_pkg::RST_SCREEN_SIZE;
            r_cfg.screen_height     <= tfv_pkg::RST_SCREEN_SIZE;
            r_cfg.raw_x_limit       <= tfv_pkg::RST_RAW_LIMIT;
            r_cfg.raw_y_limit       <= tfv_pkg::RST_RAW_LIMIT;
            r_cfg.invalid_limit     <= tfv_pkg::RST_INVALID_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> design/tfv_frame_reg.sv
// Input register stage that captures one frame transaction.
`default_nettype none

module tfv_frame_reg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [tfv_pkg::IN_TDATA_W-1:0]   i_s_tdata,   // frame_byte0 .. frame_byte7
    input  wire logic                             i_s_tuser,   // bus_error
    input  wire logic                             i_advance,
    output logic                                  o_valid,
    output logic [tfv_pkg::IN_TDATA_W-1:0]        o_data,
    output logic                                  o_bus_error
);

    logic                             r_valid;
    logic                             n_valid;
    logic [tfv_pkg::IN_TDATA_W-1:0]   r_data;
    logic                             r_bus_error;
    logic                             w_load;

    // The stage takes a new frame when empty or when its frame moves on.
    assign o_s_tready = !r_valid || i_advance;
    assign w_load     = o_s_tready && i_s_tvalid;
    assign n_valid    = o_s_tready ? i_s_tvalid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data      <= i_s_tdata;
            r_bus_error <= i_s_tuser;
        end
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_bus_error = r_bus_error;

endmodule

`default_nettype wire

>>> design/tfv_core.sv
// Frame checks, coordinate transform and touch state of the validator.
`default_nettype none

module tfv_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tfv_pkg::t_cfg                    i_cfg,
    input  wire logic                             i_valid,
    input  wire logic                             i_advance,
    input  wire logic [tfv_pkg::IN_TDATA_W-1:0]   i_data,
    input  wire logic                             i_bus_error,
    output tfv_pkg::t_result                      o_result
);

    // Touch state.
    logic [15:0] r_invalid_count;
    logic [15:0] r_last_x;
    logic [15:0] r_last_y;
    logic        r_was_pressed;
    logic [15:0] n_invalid_count;
    logic [15:0] n_last_x;
    logic [15:0] n_last_y;
    logic        n_was_pressed;

    logic [7:0]  w_b0, w_b1, w_b2, w_b3, w_b4, w_b5, w_b6, w_b7;
    logic        w_all_ff;
    logic [3:0]  w_npts;
    logic        w_status_bad;
    logic [11:0] w_raw_x;
    logic [11:0] w_raw_y;
    logic [1:0]  w_event;
    logic        w_range_bad;
    logic        w_fail;
    logic [15:0] w_count_inc;
    logic        w_limit_hit;
    logic [11:0] w_sw_x;
    logic [11:0] w_sw_y;
    logic [15:0] w_x;
    logic [15:0] w_y;
    logic        w_update;

    // Split the frame into bytes.
    assign w_b0 = i_data[7:0];
    assign w_b1 = i_data[15:8];
    assign w_b2 = i_data[23:16];
    assign w_b3 = i_data[31:24];
    assign w_b4 = i_data[39:32];
    assign w_b5 = i_data[47:40];
    assign w_b6 = i_data[55:48];
    assign w_b7 = i_data[63:56];

    // Status field and range checks.
    assign w_all_ff     = (i_data == {tfv_pkg::FRAME_BYTES{tfv_pkg::BYTE_ALL_ONES}});
    assign w_npts       = w_b1[3:0];
    assign w_status_bad = (w_b0 != 8'd0) || (w_b1[7:4] != 4'd0)
                          || (w_npts > tfv_pkg::MAX_POINTS);
    assign w_raw_x      = {w_b2[3:0], w_b3};
    assign w_raw_y      = {w_b4[3:0], w_b5};
    assign w_event      = w_b2[7:6];
    assign w_range_bad  = ({1'b0, w_raw_x} >= i_cfg.raw_x_limit)
                          || ({1'b0, w_raw_y} >= i_cfg.raw_y_limit)
                          || (w_event == tfv_pkg::EV_RESERVED);

    // A frame with a good status field restarts the count before its range check.
    assign w_fail = i_bus_error
                    || (!w_all_ff && w_status_bad)
                    || (!w_all_ff && !w_status_bad && (w_npts != 4'd0) && w_range_bad);
    assign w_count_inc = (i_bus_error || w_status_bad) ? (r_invalid_count + 16'd1) : 16'd1;
    assign w_limit_hit = (w_count_inc >= i_cfg.invalid_limit);

    // Swap, then mirror with 16-bit wrap.
    assign w_sw_x = i_cfg.swap_axes ? w_raw_y : w_raw_x;
    assign w_sw_y = i_cfg.swap_axes ? w_raw_x : w_raw_y;
    assign w_x = i_cfg.mirror_horizontal
                 ? ({3'd0, i_cfg.screen_width} - 16'd1 - {4'd0, w_sw_x})
                 : {4'd0, w_sw_x};
    assign w_y = i_cfg.mirror_vertical
                 ? ({3'd0, i_cfg.screen_height} - 16'd1 - {4'd0, w_sw_y})
                 : {4'd0, w_sw_y};

    // Result selection and next state.
    always_comb begin
        o_result        = '0;
        n_invalid_count = r_invalid_count;
        n_last_x        = r_last_x;
        n_last_y        = r_last_y;
        n_was_pressed   = r_was_pressed;
        if (w_fail) begin
            o_result.status = i_bus_error ? tfv_pkg::ST_BUS : tfv_pkg::ST_INVALID;
            if (w_limit_hit) begin
                n_invalid_count          = 16'd0;
                o_result.recover_request = 1'b1;
                n_was_pressed            = 1'b0;
                if (r_was_pressed) begin
                    o_result.status      = tfv_pkg::ST_REPORT;
                    o_result.point_count = 1'b1;
                    o_result.x_coord     = r_last_x;
                    o_result.y_coord     = r_last_y;
                    o_result.touch_event = tfv_pkg::EV_RELEASE;
                end
            end else begin
                n_invalid_count = w_count_inc;
            end
        end else if (w_all_ff) begin
            o_result.status = tfv_pkg::ST_NONE;
        end else if (w_npts == 4'd0) begin
            n_invalid_count = 16'd0;
            if (r_was_pressed) begin
                o_result.status      = tfv_pkg::ST_REPORT;
                o_result.point_count = 1'b1;
                o_result.x_coord     = r_last_x;
                o_result.y_coord     = r_last_y;
                o_result.touch_event = tfv_pkg::EV_RELEASE;
                n_was_pressed        = 1'b0;
            end else begin
                o_result.status = tfv_pkg::ST_NONE;
            end
        end else begin
            n_invalid_count          = 16'd0;
            o_result.status          = tfv_pkg::ST_REPORT;
            o_result.point_count     = 1'b1;
            o_result.x_coord         = w_x;
            o_result.y_coord         = w_y;
            o_result.touch_event     = w_event;
            o_result.touch_id        = w_b4[7:4];
            o_result.pressure_weight = w_b6;
            o_result.contact_area    = w_b7[7:4];
            n_last_x                 = w_x;
            n_last_y                 = w_y;
            n_was_pressed            = (w_event != tfv_pkg::EV_RELEASE);
        end
    end

    // State moves only when the frame is handed to the result register.
    assign w_update = i_valid && i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invalid_count <= 16'd0;
            r_last_x        <= 16'd0;
            r_last_y        <= 16'd0;
            r_was_pressed   <= 1'b0;
        end else if (w_update) begin
            r_invalid_count <= n_invalid_count;
            r_last_x        <= n_last_x;
            r_last_y        <= n_last_y;
            r_was_pressed   <= n_was_pressed;
        end
    end

endmodule

`default_nettype wire

>>> design/tfv_result_reg.sv
// Output register that holds one result transaction until it is taken.
`default_nettype none

module tfv_result_reg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire tfv_pkg::t_result                  i_result,
    output logic                                   o_advance,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // point_count, x_coord, y_coord, touch_event, touch_id, pressure_weight,
    // contact_area, recover_request, zero fill
    output logic [tfv_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    output logic [tfv_pkg::OUT_TUSER_W-1:0]        o_m_tuser    // status
);

    logic              r_valid;
    logic              n_valid;
    tfv_pkg::t_result  r_result;
    logic              w_load;

    // The register takes a result when empty or when its result is taken.
    assign o_advance = !r_valid || i_m_tready;
    assign w_load    = o_advance && i_valid;
    assign n_valid   = o_advance ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    // Pack the result fields from the lowest bit up.
    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_result.status;
    assign o_m_tdata  = {4'd0,
                         r_result.recover_request,
                         r_result.contact_area,
                         r_result.pressure_weight,
                         r_result.touch_id,
                         r_result.touch_event,
                         r_result.y_coord,
                         r_result.x_coord,
                         r_result.point_count};

endmodule

`default_nettype wire

>>> design/touch_frame_validator.sv
// Each frame is registered in the input stage and then in the output register, which
// drives o_m_tvalid. Throughput: one frame per cycle while i_m_tready is high;
// the input and output registers keep both sides moving.
// The touch state and the invalid counter update at the edge that loads each result.
// Reset (i_rst_n low, synchronous) empties both stages, clears the touch state and counter,
// and loads the configuration registers with their defaults.
`default_nettype none

`include "assert_macros.svh"

module touch_frame_validator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [tfv_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // frame_byte0 .. frame_byte7
    input  wire logic                              i_s_tuser,   // bus_error
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // point_count, x_coord, y_coord, touch_event, touch_id, pressure_weight,
    // contact_area, recover_request, zero fill
    output logic [tfv_pkg::OUT_TDATA_W-1:0]        o_m_tdata,
    output logic [tfv_pkg::OUT_TUSER_W-1:0]        o_m_tuser,   // status
    input  wire logic                              i_cfg_we,
    input  wire logic [tfv_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [tfv_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    tfv_pkg::t_cfg                    w_cfg;
    tfv_pkg::t_result                 w_result;
    logic                             w_frame_valid;
    logic [tfv_pkg::IN_TDATA_W-1:0]   w_frame_data;
    logic                             w_frame_bus_error;
    logic                             w_advance;
    logic                             w_recover_report;
    logic                             w_release_shown;
    logic                             w_none_shown;
    logic                             w_none_empty;

    tfv_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    tfv_frame_reg u_frame_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_advance   (w_advance),
        .o_valid     (w_frame_valid),
        .o_data      (w_frame_data),
        .o_bus_error (w_frame_bus_error)
    );

    tfv_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_frame_valid),
        .i_advance   (w_advance),
        .i_data      (w_frame_data),
        .i_bus_error (w_frame_bus_error),
        .o_result    (w_result)
    );

    tfv_result_reg u_result_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_frame_valid),
        .i_result   (w_result),
        .o_advance  (w_advance),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Terms of the output checks, taken from the packed result.
    assign w_recover_report = o_m_tvalid && o_m_tdata[51] && (o_m_tuser == tfv_pkg::ST_REPORT);
    assign w_release_shown  = o_m_tdata[0] && (o_m_tdata[34:33] == tfv_pkg::EV_RELEASE);
    assign w_none_shown     = o_m_tvalid && (o_m_tuser == tfv_pkg::ST_NONE);
    assign w_none_empty     = !o_m_tdata[0] && !o_m_tdata[51];

    // A captured frame always reaches an empty output register on the next edge.
    `TFV_ASSERT(a_frame_moves, i_clk, i_rst_n, w_frame_valid && !o_m_tvalid |=> o_m_tvalid)

    // A recovery shown with report status is always a release of the held touch.
    `TFV_ASSERT(a_recover_release, i_clk, i_rst_n, w_recover_report |-> w_release_shown)

    // A frame with nothing new never carries a point or a recovery.
    `TFV_ASSERT(a_none_is_empty, i_clk, i_rst_n, w_none_shown |-> w_none_empty)

    // Reset leaves both stages empty on the following edge.
    `TFV_ASSERT_ALWAYS(a_reset_empty, i_clk, !$past(i_rst_n) |-> !o_m_tvalid && !w_frame_valid)

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the touch frame validator stream block.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned FRAMES_PER_PHASE = 105;

    // One row of the directed script: a register write or a frame transaction.
    typedef struct {
        bit                             is_cfg;
        logic [tfv_pkg::CFG_ADDR_W-1:0] addr;
        logic [tfv_pkg::CFG_DATA_W-1:0] wdata;
        logic                           bus;
        logic [tfv_pkg::IN_TDATA_W-1:0] frame;
        bit                             typed;
        tfv_pkg::t_result               want;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [tfv_pkg::IN_TDATA_W-1:0]  i_s_tdata;    // frame_byte0 .. frame_byte7
    logic                            i_s_tuser;    // bus_error
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    // point_count, x_coord, y_coord, touch_event, touch_id, pressure_weight,
    // contact_area, recover_request, zero fill
    logic [tfv_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic [tfv_pkg::OUT_TUSER_W-1:0] o_m_tuser;    // status
    logic                            i_cfg_we;
    logic [tfv_pkg::CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [tfv_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;

    // Shadow copy of the block's registers and touch state.
    tfv_pkg::t_cfg settings;
    logic [15:0]   bad_frame_count;
    logic [15:0]   held_x;
    logic [15:0]   held_y;
    logic          touch_held;

    tfv_pkg::t_result pending_results[$];
    t_row             script[$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned frames_sent = 0;
    int unsigned recoveries_expected = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    bit          out_stalls = 1'b1;
    bit          in_burst = 1'b0;

    touch_frame_validator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        $display("[%0t] result %0d: %s got 0x%0h want 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            report_mismatch(name, got, want);
    endtask

    function automatic logic [tfv_pkg::IN_TDATA_W-1:0] mk_frame(
        input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
        input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
        input logic [7:0] b6, input logic [7:0] b7);
        return {b7, b6, b5, b4, b3, b2, b1, b0};
    endfunction

    function automatic tfv_pkg::t_result mk_result(
        input logic [1:0] status, input logic pc, input logic [15:0] x,
        input logic [15:0] y, input logic [1:0] ev, input logic [3:0] id,
        input logic [7:0] weight, input logic [3:0] area, input logic rec);
        tfv_pkg::t_result r;
        r.status          = status;
        r.point_count     = pc;
        r.x_coord         = x;
        r.y_coord         = y;
        r.touch_event     = ev;
        r.touch_id        = id;
        r.pressure_weight = weight;
        r.contact_area    = area;
        r.recover_request = rec;
        return r;
    endfunction

    // A release is reported at the last known position.
    function automatic void fill_release(inout tfv_pkg::t_result r);
        r.status      = tfv_pkg::ST_REPORT;
        r.point_count = 1'b1;
        r.x_coord     = held_x;
        r.y_coord     = held_y;
        r.touch_event = tfv_pkg::EV_RELEASE;
    endfunction

    // Counts a bad frame and raises recovery once the limit is reached.
    function automatic void note_bad_frame(inout tfv_pkg::t_result r,
                                           input logic [1:0] status);
        bad_frame_count = bad_frame_count + 16'd1;
        r.status = status;
        if (bad_frame_count >= settings.invalid_limit) begin
            bad_frame_count   = '0;
            r.recover_request = 1'b1;
            recoveries_expected++;
            if (touch_held)
                fill_release(r);
            touch_held = 1'b0;
        end
    endfunction

    // Predicts the result of one frame transaction and advances the shadow state.
    function automatic tfv_pkg::t_result judge_frame(input logic bus,
                                                     input logic [tfv_pkg::IN_TDATA_W-1:0] fr);
        tfv_pkg::t_result r;
        logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
        logic [11:0] raw_x, raw_y;
        logic [15:0] x, y, t;
        logic [1:0]  ev;
        logic [3:0]  npts;
        {b7, b6, b5, b4, b3, b2, b1, b0} = fr;
        r = '0;
        if (bus) begin
            note_bad_frame(r, tfv_pkg::ST_BUS);
            return r;
        end
        if (fr == {tfv_pkg::FRAME_BYTES{tfv_pkg::BYTE_ALL_ONES}}) begin
            r.status = tfv_pkg::ST_NONE;
            return r;
        end
        npts = b1[3:0];
        if (b0 != 8'd0 || b1[7:4] != 4'd0 || npts > tfv_pkg::MAX_POINTS) begin
            note_bad_frame(r, tfv_pkg::ST_INVALID);
            return r;
        end
        // A good header clears the count even if the point is rejected below.
        bad_frame_count = '0;
        if (npts == 4'd0) begin
            if (touch_held) begin
                fill_release(r);
                touch_held = 1'b0;
            end else begin
                r.status = tfv_pkg::ST_NONE;
            end
            return r;
        end
        raw_x = {b2[3:0], b3};
        raw_y = {b4[3:0], b5};
        ev    = b2[7:6];
        if ({1'b0, raw_x} >= settings.raw_x_limit || {1'b0, raw_y} >= settings.raw_y_limit ||
            ev == tfv_pkg::EV_RESERVED) begin
            note_bad_frame(r, tfv_pkg::ST_INVALID);
            return r;
        end
        x = {4'd0, raw_x};
        y = {4'd0, raw_y};
        if (settings.swap_axes) begin
            t = x;
            x = y;
            y = t;
        end
        if (settings.mirror_horizontal)
            x = {3'd0, settings.screen_width} - 16'd1 - x;
        if (settings.mirror_vertical)
            y = {3'd0, settings.screen_height} - 16'd1 - y;
        r = mk_result(tfv_pkg::ST_REPORT, 1'b1, x, y, ev, b4[7:4], b6, b7[7:4], 1'b0);
        held_x     = x;
        held_y     = y;
        touch_held = (ev != tfv_pkg::EV_RELEASE);
        return r;
    endfunction

    // Register write, mirrored into the shadow copy.
    task automatic cfg_write(input logic [tfv_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [tfv_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (addr)
            tfv_pkg::CFG_SWAP_AXES:     settings.swap_axes         = val[0];
            tfv_pkg::CFG_MIRROR_H:      settings.mirror_horizontal = val[0];
            tfv_pkg::CFG_MIRROR_V:      settings.mirror_vertical   = val[0];
            tfv_pkg::CFG_SCREEN_WIDTH:  settings.screen_width      = val[12:0];
            tfv_pkg::CFG_SCREEN_HEIGHT: settings.screen_height     = val[12:0];
            tfv_pkg::CFG_RAW_X_LIMIT:   settings.raw_x_limit       = val[12:0];
            tfv_pkg::CFG_RAW_Y_LIMIT:   settings.raw_y_limit       = val[12:0];
            tfv_pkg::CFG_INVALID_LIMIT: settings.invalid_limit     = val;
            default: ;
        endcase
    endtask

    // Sender idle length: mostly none or short, now and then long.
    function automatic int unsigned next_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (in_burst || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Offers one frame until accepted; valid stays high only for a back-to-back frame.
    task automatic send_frame(input logic bus, input logic [tfv_pkg::IN_TDATA_W-1:0] fr,
                              input bit typed, input tfv_pkg::t_result want,
                              input int unsigned gap);
        tfv_pkg::t_result exp;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= fr;
        i_s_tuser  <= bus;
        do @(posedge i_clk); while (!o_s_tready);
        exp = judge_frame(bus, fr);
        if (typed)
            exp = want;
        pending_results.push_back(exp);
        frames_sent++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [11:0] pick_coord(input logic [12:0] lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 12'd0;
        else if (r < 16)
            return 12'(lim - 13'd1);
        else if (r < 24 && lim < 13'd4096)
            return lim[11:0];
        else if (r < 88)
            return 12'($urandom_range(0, lim - 1));
        return 12'($urandom);
    endfunction

    function automatic logic [12:0] rand_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 13'd1;
        else if (r < 3)
            return 13'd4096;
        return 13'($urandom_range(1, 4096));
    endfunction

    function automatic logic [12:0] rand_raw_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 13'd4096;
        else if (r < 45)
            return 13'd1;
        return 13'($urandom_range(1, 4096));
    endfunction

    // Random frame: mostly well-formed points and lifts, the rest noise and broken frames.
    task automatic make_frame(output logic bus, output logic [tfv_pkg::IN_TDATA_W-1:0] fr);
        logic [7:0]  b [tfv_pkg::FRAME_BYTES];
        logic [11:0] x, y;
        int unsigned r;
        bus = 1'b0;
        foreach (b[k])
            b[k] = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 46) begin
            x    = pick_coord(settings.raw_x_limit);
            y    = pick_coord(settings.raw_y_limit);
            b[0] = 8'd0;
            b[1] = {4'd0, 4'($urandom_range(1, tfv_pkg::MAX_POINTS))};
            b[2] = {2'($urandom_range(0, 2)), b[2][5:4], x[11:8]};
            b[3] = x[7:0];
            b[4] = {b[4][7:4], y[11:8]};
            b[5] = y[7:0];
        end else if (r < 60) begin
            b[0] = 8'd0;
            b[1] = 8'd0;
        end else if (r < 67) begin
            foreach (b[k])
                b[k] = tfv_pkg::BYTE_ALL_ONES;
        end else if (r < 75) begin
            bus = 1'b1;
        end else if (r < 90) begin
            case ($urandom_range(0, 2))
                0: b[0] = 8'($urandom_range(1, 255));
                1: begin
                    b[0] = 8'd0;
                    b[1] = {4'($urandom_range(1, 15)), b[1][3:0]};
                end
                default: begin
                    b[0] = 8'd0;
                    b[1] = {4'd0, 4'($urandom_range(tfv_pkg::MAX_POINTS + 1, 15))};
                end
            endcase
        end else if (r < 96) begin
            b[0] = 8'd0;
            b[1] = {4'd0, 4'($urandom_range(1, tfv_pkg::MAX_POINTS))};
            b[2] = {tfv_pkg::EV_RESERVED, b[2][5:0]};
        end
        fr = mk_frame(b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]);
    endtask

    // Writes every register with a setting chosen for the phase.
    task automatic configure_phase(input int unsigned ph);
        logic        swap, mh, mv;
        logic [12:0] sw, sh, rxl, ryl;
        logic [15:0] il;
        swap = 1'($urandom);
        mh   = 1'($urandom);
        mv   = 1'($urandom);
        sw   = rand_size();
        sh   = rand_size();
        rxl  = rand_raw_limit();
        ryl  = rand_raw_limit();
        il   = 16'($urandom_range(1, 20));
        case (ph)
            0: il = 16'($urandom_range(1, 6));
            1: begin
                // Lowest screen sizes with every transform on: mirrored values wrap.
                {swap, mh, mv} = 3'b111;
                sw  = 13'd1;
                sh  = 13'd1;
                rxl = 13'd4096;
                ryl = 13'd4096;
                il  = 16'd1;
            end
            2: begin
                {swap, mh, mv} = 3'b000;
                sw  = 13'd4096;
                sh  = 13'd4096;
                rxl = 13'd4096;
                ryl = 13'd4096;
                il  = 16'd3;
            end
            3: begin
                rxl = 13'($urandom_range(1, 4096));
                ryl = 13'($urandom_range(1, 4096));
                il  = 16'($urandom_range(2, 8));
            end
            4: begin
                sw  = 13'd4096;
                sh  = 13'd4096;
                rxl = 13'd4096;
                ryl = 13'd4096;
                il  = 16'hFFFF;
            end
            default: ;
        endcase
        cfg_write(tfv_pkg::CFG_SWAP_AXES, {15'd0, swap});
        cfg_write(tfv_pkg::CFG_MIRROR_H, {15'd0, mh});
        cfg_write(tfv_pkg::CFG_MIRROR_V, {15'd0, mv});
        cfg_write(tfv_pkg::CFG_SCREEN_WIDTH, {3'd0, sw});
        cfg_write(tfv_pkg::CFG_SCREEN_HEIGHT, {3'd0, sh});
        cfg_write(tfv_pkg::CFG_RAW_X_LIMIT, {3'd0, rxl});
        cfg_write(tfv_pkg::CFG_RAW_Y_LIMIT, {3'd0, ryl});
        cfg_write(tfv_pkg::CFG_INVALID_LIMIT, il);
        settings_used++;
    endtask

    function automatic void add_frame(input logic bus,
                                      input logic [tfv_pkg::IN_TDATA_W-1:0] fr);
        t_row row;
        row       = '{default: '0};
        row.bus   = bus;
        row.frame = fr;
        script.push_back(row);
    endfunction

    function automatic void add_typed(input logic bus,
                                      input logic [tfv_pkg::IN_TDATA_W-1:0] fr,
                                      input tfv_pkg::t_result want);
        t_row row;
        row       = '{default: '0};
        row.bus   = bus;
        row.frame = fr;
        row.typed = 1'b1;
        row.want  = want;
        script.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [tfv_pkg::CFG_ADDR_W-1:0] addr,
                                    input logic [tfv_pkg::CFG_DATA_W-1:0] val);
        t_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.addr   = addr;
        row.wdata  = val;
        script.push_back(row);
    endfunction

    // Output side: random stalls, plus a long hold-off when the stimulus asks for one.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                int unsigned r;
                r = $urandom_range(0, 99);
                i_m_tready <= 1'b1;
                if (out_stalls && r < 25)
                    stall_left = (r < 2) ? $urandom_range(20, 60) : $urandom_range(1, 3);
            end
        end
    end

    // Checks each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        tfv_pkg::t_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status          = o_m_tuser;
            got.point_count     = o_m_tdata[0];
            got.x_coord         = o_m_tdata[16:1];
            got.y_coord         = o_m_tdata[32:17];
            got.touch_event     = o_m_tdata[34:33];
            got.touch_id        = o_m_tdata[38:35];
            got.pressure_weight = o_m_tdata[46:39];
            got.contact_area    = o_m_tdata[50:47];
            got.recover_request = o_m_tdata[51];
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", got.status, 0);
            end else begin
                want = pending_results.pop_front();
                compare_field("status", got.status, want.status);
                compare_field("point_count", got.point_count, want.point_count);
                compare_field("x_coord", got.x_coord, want.x_coord);
                compare_field("y_coord", got.y_coord, want.y_coord);
                compare_field("touch_event", got.touch_event, want.touch_event);
                compare_field("touch_id", got.touch_id, want.touch_id);
                compare_field("pressure_weight", got.pressure_weight, want.pressure_weight);
                compare_field("contact_area", got.contact_area, want.contact_area);
                compare_field("recover_request", got.recover_request, want.recover_request);
            end
            results_seen++;
        end
    end

    // Stimulus sequence.
    initial begin
        logic                           bus;
        logic [tfv_pkg::IN_TDATA_W-1:0] fr;
        tfv_pkg::t_result               none;
        none = '0;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;

        settings.swap_axes         = 1'b0;
        settings.mirror_horizontal = 1'b0;
        settings.mirror_vertical   = 1'b0;
        settings.screen_width      = tfv_pkg::RST_SCREEN_SIZE;
        settings.screen_height     = tfv_pkg::RST_SCREEN_SIZE;
        settings.raw_x_limit       = tfv_pkg::RST_RAW_LIMIT;
        settings.raw_y_limit       = tfv_pkg::RST_RAW_LIMIT;
        settings.invalid_limit     = tfv_pkg::RST_INVALID_LIMIT;
        bad_frame_count = '0;
        held_x          = '0;
        held_y          = '0;
        touch_held      = 1'b0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script under reset settings: idle frame, bus errors, header faults, no points.
        add_typed(1'b0, {tfv_pkg::FRAME_BYTES{tfv_pkg::BYTE_ALL_ONES}},
                  mk_result(tfv_pkg::ST_NONE, 0, 0, 0, tfv_pkg::EV_DOWN, 0, 0, 0, 0));
        add_typed(1'b1, '0,
                  mk_result(tfv_pkg::ST_BUS, 0, 0, 0, tfv_pkg::EV_DOWN, 0, 0, 0, 0));
        add_typed(1'b1, {tfv_pkg::FRAME_BYTES{tfv_pkg::BYTE_ALL_ONES}},
                  mk_result(tfv_pkg::ST_BUS, 0, 0, 0, tfv_pkg::EV_DOWN, 0, 0, 0, 0));
        add_typed(1'b0, mk_frame(8'hFF, 8'h01, 0, 0, 0, 0, 0, 0),
                  mk_result(tfv_pkg::ST_INVALID, 0, 0, 0, tfv_pkg::EV_DOWN, 0, 0, 0, 0));
        add_typed(1'b0, mk_frame(8'h00, 8'hF1, 0, 0, 0, 0, 0, 0),
                  mk_result(tfv_pkg::ST_INVALID, 0, 0, 0, tfv_pkg::EV_DOWN, 0, 0, 0, 0));
        add_typed(1'b0, mk_frame(8'h00, 8'h06, 0, 0, 0, 0, 0, 0),
                  mk_result(tfv_pkg::ST_INVALID, 0, 0, 0, tfv_pkg::EV_DOWN, 0, 0, 0, 0));
        add_typed(1'b0, mk_frame(8'h00, 8'h0F, 0, 0, 0, 0, 0, 0),
                  mk_result(tfv_pkg::ST_INVALID, 0, 0, 0, tfv_pkg::EV_DOWN, 0, 0, 0, 0));
        add_typed(1'b0, '0,
                  mk_result(tfv_pkg::ST_NONE, 0, 0, 0, tfv_pkg::EV_DOWN, 0, 0, 0, 0));
        // Largest point, then a lift releases it at the same place.
        add_typed(1'b0, mk_frame(8'h00, 8'h05, 8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                  mk_result(tfv_pkg::ST_REPORT, 1, 4095, 4095, tfv_pkg::EV_DOWN,
                            4'hF, 8'hFF, 4'hF, 0));
        add_typed(1'b0, mk_frame(8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                  mk_result(tfv_pkg::ST_REPORT, 1, 4095, 4095, tfv_pkg::EV_RELEASE,
                            0, 0, 0, 0));
        add_typed(1'b0, mk_frame(8'h00, 8'h01, 8'h80, 0, 0, 0, 0, 0),
                  mk_result(tfv_pkg::ST_REPORT, 1, 0, 0, tfv_pkg::EV_CONTACT, 0, 0, 0, 0));
        // Reserved event code after a good header leaves the count at one.
        add_typed(1'b0, mk_frame(8'h00, 8'h01, 8'hC0, 0, 0, 0, 0, 0),
                  mk_result(tfv_pkg::ST_INVALID, 0, 0, 0, tfv_pkg::EV_DOWN, 0, 0, 0, 0));
        add_frame(1'b0, mk_frame(8'h00, 8'h02, 8'h45, 8'h67, 8'hA8, 8'h9C, 8'h3C, 8'h5A));
        add_frame(1'b0, mk_frame(8'h00, 8'h00, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33));
        add_frame(1'b0, mk_frame(8'h00, 8'h03, 8'h9A, 8'h01, 8'h52, 8'hF0, 8'h80, 8'hC3));
        // Tight limits with every transform, then recovery with and without a held touch.
        add_cfg(tfv_pkg::CFG_INVALID_LIMIT, 16'd2);
        add_cfg(tfv_pkg::CFG_RAW_X_LIMIT, 16'd100);
        add_cfg(tfv_pkg::CFG_RAW_Y_LIMIT, 16'd1);
        add_cfg(tfv_pkg::CFG_SWAP_AXES, 16'd1);
        add_cfg(tfv_pkg::CFG_MIRROR_H, 16'd1);
        add_cfg(tfv_pkg::CFG_SCREEN_WIDTH, 16'd1);
        add_cfg(tfv_pkg::CFG_MIRROR_V, 16'd1);
        add_cfg(tfv_pkg::CFG_SCREEN_HEIGHT, 16'd4096);
        add_frame(1'b0, mk_frame(8'h00, 8'h01, 8'h00, 8'd50, 8'h30, 8'h00, 8'h11, 8'h20));
        add_frame(1'b0, mk_frame(8'h00, 8'h01, 8'h00, 8'd100, 8'h30, 8'h00, 8'h11, 8'h20));
        add_frame(1'b1, '0);
        add_frame(1'b1, mk_frame(8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5));
        add_frame(1'b0, mk_frame(8'h01, 8'h01, 0, 0, 0, 0, 0, 0));
        add_frame(1'b0, mk_frame(8'h00, 8'h01, 8'h00, 8'h05, 8'h00, 8'h01, 8'h00, 8'h00));
        add_frame(1'b0, {tfv_pkg::FRAME_BYTES{tfv_pkg::BYTE_ALL_ONES}});

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                wait_drained();
                cfg_write(script[i].addr, script[i].wdata);
            end else begin
                send_frame(script[i].bus, script[i].frame, script[i].typed, script[i].want,
                           next_gap());
            end
        end

        // Random phases, each under its own register setting.
        for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_drained();
            configure_phase(ph);
            out_stalls = (ph != 4);
            in_burst   = (ph == 4);
            for (int unsigned k = 0; k < FRAMES_PER_PHASE; k++) begin
                // Long output hold-off while frames keep coming back to back.
                if (ph == 2 && k == 30)
                    hold_left = HOLD_CYCLES;
                // Sender pauses until everything is out.
                if (ph == 3 && k == 50)
                    wait_drained();
                make_frame(bus, fr);
                send_frame(bus, fr, 1'b0, none,
                           (ph == 2 && k >= 30 && k < 70) ? 0 : next_gap());
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Summary: %0d frames in, %0d results checked, %0d register settings.",
                 frames_sent, results_seen, settings_used);
        $display("Summary: %0d recovery requests predicted; stalls, hold-off and drain covered.",
                 recoveries_expected);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
